// File: sv/kfc_pkg.sv
`timescale 1ns / 1ps
package kfc_pkg;

  localparam int OPERAND_BITS_DEF   = 32;
  localparam int DISPLAY_DIGITS_DEF = 6;
  localparam int KEY_W              = 5;
  localparam int BCD_W              = 24;
  localparam int LED_W              = 4;
  localparam int QDEPTH             = 2;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 5'd9;
  localparam logic [KEY_W-1:0] KEY_ADD       = 5'd10;
  localparam logic [KEY_W-1:0] KEY_DIV       = 5'd13;
  localparam logic [KEY_W-1:0] KEY_EQUALS    = 5'd14;
  localparam logic [KEY_W-1:0] KEY_CLEAR     = 5'd15;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  localparam logic [LED_W-1:0] LED_ADD = 4'h1;
  localparam logic [LED_W-1:0] LED_SUB = 4'h2;
  localparam logic [LED_W-1:0] LED_MUL = 4'h4;
  localparam logic [LED_W-1:0] LED_DIV = 4'h8;

  typedef enum logic [1:0] {
    CMD_DIGIT,
    CMD_OPER,
    CMD_EQUALS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [3:0] arg;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  function automatic logic [LED_W-1:0] led_for(input logic [2:0] op);
    logic [LED_W-1:0] l;
    unique case (op)
      OP_ADD:  l = LED_ADD;
      OP_SUB:  l = LED_SUB;
      OP_MUL:  l = LED_MUL;
      OP_DIV:  l = LED_DIV;
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

// File: sv/kfc_front.sv
`timescale 1ns / 1ps
module kfc_front import kfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             full_o,
  output cmd_req_t         req_o,
  input  logic             take_i
);

  cmd_t        mem_q [QDEPTH];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        acc, keep, deq;
  cmd_t        cmd;

  always_comb begin
    cmd  = '{kind: CMD_DIGIT, arg: key_i[3:0]};
    keep = 1'b1;
    priority if (key_i <= KEY_DIGIT_MAX) begin
      cmd.kind = CMD_DIGIT;
    end else if (key_i <= KEY_DIV) begin
      cmd.kind = CMD_OPER;
      cmd.arg  = {1'b0, key_i[2:0] - 3'd1};
    end else if (key_i == KEY_CLEAR) begin
      cmd.kind = CMD_OPER;
      cmd.arg  = {1'b0, OP_CLEAR};
    end else if (key_i == KEY_EQUALS) begin
      cmd.kind = CMD_EQUALS;
    end else begin
      keep = 1'b0;
    end
  end

  assign full_o = (cnt_q == 2'(QDEPTH));
  assign acc    = push_i && !full_o && keep;
  assign deq    = take_i && (cnt_q != '0);
  assign req_o  = '{valid: (cnt_q != '0), cmd: mem_q[rd_q]};

  always_comb begin
    wr_d  = wr_q ^ acc;
    rd_d  = rd_q ^ deq;
    cnt_d = cnt_q + 2'(acc) - 2'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem_q[wr_q] <= cmd;
    end
  end

endmodule

// File: sv/kfc_back.sv
`timescale 1ns / 1ps
module kfc_back import kfc_pkg::*; #(
  parameter int OPERAND_BITS   = OPERAND_BITS_DEF,
  parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_req_t         req_i,
  output logic             take_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [BCD_W-1:0] display_bcd_o,
  output logic [LED_W-1:0] op_leds_o
);

  localparam int N  = OPERAND_BITS;
  localparam int BD = (N * 3) / 10 + 1;
  localparam int EW = BD * 4 + BCD_W;
  localparam int CW = $clog2(N + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DFIX = 3'd3;
  localparam logic [2:0] S_BCD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       st_q, st_d;
  logic [N-1:0]     cur_q, cur_d, prev_q, prev_d, last_q, last_d;
  logic [2:0]       pend_q, pend_d;
  logic [LED_W-1:0] led_q, led_d;
  logic [N-1:0]     wa_q, wa_d, wb_q, wb_d, acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [N-1:0]     bin_q, bin_d;
  logic [BD*4-1:0]  bcd_q, bcd_d;
  logic             ov_q, ov_d;
  logic [BCD_W-1:0] disp_q, disp_d;
  logic [LED_W-1:0] oled_q, oled_d;

  logic             commit, show;
  logic [N-1:0]     cval, sval;
  logic [N:0]       trial;
  logic [BD*4-1:0]  adj;
  logic [EW-1:0]    ext;
  logic             last_it, out_free;

  function automatic logic [N-1:0] mag(input logic [N-1:0] v);
    return v[N-1] ? (~v + N'(1)) : v;
  endfunction

  assign last_it  = (cnt_q == CW'(N - 1));
  assign out_free = !ov_q || pop_i;
  assign trial    = {acc_q, wa_q[N-1]} - {1'b0, wb_q};

  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < BD; i++) begin
      if (bcd_q[i*4+:4] >= 4'd5) adj[i*4+:4] = bcd_q[i*4+:4] + 4'd3;
    end
    ext    = EW'(bcd_q);
    disp_d = '0;
    for (int i = 0; i < BCD_W / 4; i++) begin
      if (i < DISPLAY_DIGITS) disp_d[i*4+:4] = ext[i*4+:4];
    end
  end

  always_comb begin
    st_d = st_q; cur_d = cur_q; prev_d = prev_q; last_d = last_q;
    pend_d = pend_q; led_d = led_q;
    wa_d = wa_q; wb_d = wb_q; acc_d = acc_q; neg_d = neg_q; cnt_d = cnt_q;
    bin_d = bin_q; bcd_d = bcd_q;
    ov_d = ov_q && !pop_i; oled_d = oled_q;
    take_o = 1'b0; commit = 1'b0; cval = '0; show = 1'b0; sval = '0;

    unique case (st_q)
      S_IDLE: begin
        if (req_i.valid) begin
          take_o = 1'b1;
          unique case (req_i.cmd.kind)
            CMD_DIGIT: begin
              cur_d = {cur_q[N-4:0], 3'b0} + {cur_q[N-2:0], 1'b0}
                      + N'(req_i.cmd.arg);
              show = 1'b1; sval = cur_d;
            end
            CMD_OPER: begin
              prev_d = cur_q;
              cur_d  = '0;
              pend_d = req_i.cmd.arg[2:0];
              led_d  = led_for(req_i.cmd.arg[2:0]);
              show = 1'b1; sval = cur_q;
            end
            CMD_EQUALS: begin
              unique case (pend_q)
                OP_ADD:  begin commit = 1'b1; cval = prev_q + cur_q; end
                OP_SUB:  begin commit = 1'b1; cval = prev_q - cur_q; end
                OP_CLEAR: begin commit = 1'b1; cval = '0; end
                OP_MUL: begin
                  wa_d = prev_q; wb_d = cur_q; acc_d = '0; cnt_d = '0;
                  st_d = S_MUL;
                end
                OP_DIV: begin
                  if (cur_q == '0) begin
                    commit = 1'b1; cval = '0;
                  end else begin
                    wa_d = mag(prev_q); wb_d = mag(cur_q); acc_d = '0;
                    neg_d = prev_q[N-1] ^ cur_q[N-1]; cnt_d = '0;
                    st_d = S_DIV;
                  end
                end
                default: begin commit = 1'b1; cval = last_q; end
              endcase
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (wb_q[0]) acc_d = acc_q + wa_q;
        wa_d  = {wa_q[N-2:0], 1'b0};
        wb_d  = {1'b0, wb_q[N-1:1]};
        cnt_d = cnt_q + CW'(1);
        if (last_it) begin
          commit = 1'b1; cval = acc_d;
        end
      end
      S_DIV: begin
        if (!trial[N]) acc_d = trial[N-1:0];
        else           acc_d = {acc_q[N-2:0], wa_q[N-1]};
        wa_d  = {wa_q[N-2:0], !trial[N]};
        cnt_d = cnt_q + CW'(1);
        if (last_it) st_d = S_DFIX;
      end
      S_DFIX: begin
        commit = 1'b1;
        cval   = neg_q ? (~wa_q + N'(1)) : wa_q;
      end
      S_BCD: begin
        bcd_d = {adj[BD*4-2:0], bin_q[N-1]};
        bin_d = {bin_q[N-2:0], 1'b0};
        cnt_d = cnt_q + CW'(1);
        if (last_it) st_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ov_d = 1'b1; oled_d = led_q;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase

    if (commit) begin
      cur_d = cval; prev_d = '0; last_d = cval;
      pend_d = OP_NONE; led_d = '0;
      show = 1'b1; sval = cval;
    end
    if (show) begin
      bin_d = mag(sval); bcd_d = '0; cnt_d = '0;
      st_d = S_BCD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cur_q <= '0; prev_q <= '0; last_q <= '0;
      pend_q <= OP_NONE; led_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cur_q <= cur_d; prev_q <= prev_d; last_q <= last_d;
      pend_q <= pend_d; led_q <= led_d; cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= wa_d; wb_q <= wb_d; acc_q <= acc_d; neg_q <= neg_d;
    bin_q <= bin_d; bcd_q <= bcd_d;
    if (st_q == S_DONE && out_free) begin
      disp_q <= disp_d;
      oled_q <= oled_d;
    end
  end

  assign empty_o       = !ov_q;
  assign display_bcd_o = disp_q;
  assign op_leds_o     = oled_q;

  a_commit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (pend_q == OP_NONE) && (prev_q == '0) && (led_q == '0))
    else $error("equals left state behind");
  a_led_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(led_q))
    else $error("led pattern not one-hot");
  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE) && ov_q && !pop_i |=> (st_q == S_DONE) && ov_q)
    else $error("result overwritten");
  a_take_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> (st_q == S_IDLE) && req_i.valid)
    else $error("command taken while busy");

endmodule

// File: sv/keypad_four_function_calculator_unit.sv
`timescale 1ns / 1ps
// channel  | ports                              | handshake
// key in   | key_i                              | push, full
// result   | display_bcd_o, op_leds_o           | pop, empty
//
// Digit and operation keys pass through the double-dabble BCD converter
// (one bit per cycle). Equals with mul or div first runs the shift-add /
// restoring unit. Reset clears the operands, pending op and op LED state,
// but not the op_leds_o output register. A two-entry key queue
// lets keys in while the back end works or a result waits for pop.
module keypad_four_function_calculator_unit import kfc_pkg::*; #(
  parameter int OPERAND_BITS   = OPERAND_BITS_DEF,
  parameter int DISPLAY_DIGITS = DISPLAY_DIGITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [KEY_W-1:0] key_i,
  input  logic             pop,
  output logic             empty,
  output logic [BCD_W-1:0] display_bcd_o,
  output logic [LED_W-1:0] op_leds_o
);

  cmd_req_t req;
  logic     take;

  kfc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .key_i  (key_i),
    .full_o (full),
    .req_o  (req),
    .take_i (take)
  );

  kfc_back #(
    .OPERAND_BITS   (OPERAND_BITS),
    .DISPLAY_DIGITS (DISPLAY_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .take_o        (take),
    .pop_i         (pop),
    .empty_o       (empty),
    .display_bcd_o (display_bcd_o),
    .op_leds_o     (op_leds_o)
  );

endmodule
